// ----- hdl/rmf_pkg.sv -----
// Shared types, constants and control words for the reply message framer.
`timescale 1ns / 1ps

package rmf_pkg;

  localparam int MAX_DEPTH = 8;
  localparam int NUM_W     = 31;
  localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);
  localparam int LVL_W     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  typedef enum logic [3:0] {
    PH_TYPE,
    PH_LINE,
    PH_LINE_LF,
    PH_NUM_FIRST,
    PH_NUM_SIGNED,
    PH_NUM,
    PH_NUM_LF,
    PH_PAYLOAD,
    PH_PAY_CR,
    PH_PAY_LF
  } phase_t;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_LINE,
    KIND_BULK,
    KIND_ARRAY
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_TYPE,
    ERR_HEADER,
    ERR_DEPTH
  } err_t;

  typedef struct packed {
    logic  is_cr;
    logic  is_lf;
    logic  is_digit;
    logic  is_minus;
    logic  is_line_type;
    logic  is_bulk_type;
    logic  is_array_type;
    logic  num_ovf;
    logic  hdr_zero;
    logic  hdr_one;
    logic  negative;
    kind_t kind;
    logic  stack_full;
    logic  pay_last;
    logic  tree_done;
  } dp_status_t;

  typedef struct packed {
    logic start_line;
    logic start_num;
    logic set_neg;
    logic add_digit;
    logic load_pay;
    logic dec_pay;
    logic push;
    logic pop;
    logic restart;
  } dp_cmd_t;

endpackage

// ----- hdl/rmf_ctrl.sv -----
// Framing state machine: tracks the phase of the current element and issues datapath commands.
`timescale 1ns / 1ps

module rmf_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  rmf_pkg::dp_status_t status,
  output rmf_pkg::dp_cmd_t   cmd,
  output rmf_pkg::err_t      err,
  output logic               done,
  output logic               pay
);
  import rmf_pkg::*;

  phase_t phase;
  phase_t phase_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_TYPE;
    end else begin
      phase <= phase_next;
    end
  end

  always_comb begin
    cmd  = '0;
    err  = ERR_NONE;
    done = 1'b0;
    pay  = 1'b0;
    if (step) begin
      unique case (phase)
        PH_TYPE: begin
          if (status.is_line_type) begin
            cmd.start_line = 1'b1;
          end else if (status.is_bulk_type || status.is_array_type) begin
            cmd.start_num = 1'b1;
          end else begin
            err = ERR_TYPE;
          end
        end
        PH_LINE: begin
        end
        PH_LINE_LF: begin
          if (status.is_lf) begin
            cmd.pop = 1'b1;
            done    = status.tree_done;
          end
        end
        PH_NUM_FIRST: begin
          if (status.is_minus) begin
            cmd.set_neg = 1'b1;
          end else if (status.is_digit) begin
            cmd.add_digit = 1'b1;
          end else begin
            err = ERR_HEADER;
          end
        end
        PH_NUM_SIGNED: begin
          if (status.is_digit) begin
            cmd.add_digit = 1'b1;
          end else begin
            err = ERR_HEADER;
          end
        end
        PH_NUM: begin
          if (!status.is_cr) begin
            if (!status.is_digit || status.num_ovf) begin
              err = ERR_HEADER;
            end else begin
              cmd.add_digit = 1'b1;
            end
          end
        end
        PH_NUM_LF: begin
          if (!status.is_lf) begin
            err = ERR_HEADER;
          end else if (status.kind == KIND_BULK) begin
            if (status.negative && status.hdr_one) begin
              cmd.pop = 1'b1;
              done    = status.tree_done;
            end else if (status.hdr_zero) begin
            end else if (status.negative) begin
              err = ERR_HEADER;
            end else begin
              cmd.load_pay = 1'b1;
            end
          end else if (status.kind == KIND_ARRAY) begin
            if (status.negative || status.hdr_zero) begin
              cmd.pop = 1'b1;
              done    = status.tree_done;
            end else if (status.stack_full) begin
              err = ERR_DEPTH;
            end else begin
              cmd.push = 1'b1;
            end
          end else begin
            err = ERR_HEADER;
          end
        end
        PH_PAYLOAD: begin
          pay         = 1'b1;
          cmd.dec_pay = 1'b1;
        end
        PH_PAY_CR: begin
          if (!status.is_cr) begin
            err = ERR_HEADER;
          end
        end
        PH_PAY_LF: begin
          if (status.is_lf) begin
            cmd.pop = 1'b1;
            done    = status.tree_done;
          end else begin
            err = ERR_HEADER;
          end
        end
        default: begin
          err = ERR_HEADER;
        end
      endcase
      if (err != ERR_NONE) begin
        cmd         = '0;
        cmd.restart = 1'b1;
        done        = 1'b0;
        pay         = 1'b0;
      end
    end
  end

  always_comb begin
    phase_next = phase;
    if (step) begin
      if (err != ERR_NONE) begin
        phase_next = PH_TYPE;
      end else begin
        unique case (phase)
          PH_TYPE: begin
            phase_next = status.is_line_type ? PH_LINE : PH_NUM_FIRST;
          end
          PH_LINE: begin
            if (status.is_cr) begin
              phase_next = PH_LINE_LF;
            end
          end
          PH_LINE_LF: begin
            if (status.is_lf) begin
              phase_next = PH_TYPE;
            end else if (!status.is_cr) begin
              phase_next = PH_LINE;
            end
          end
          PH_NUM_FIRST: begin
            phase_next = status.is_minus ? PH_NUM_SIGNED : PH_NUM;
          end
          PH_NUM_SIGNED: begin
            phase_next = PH_NUM;
          end
          PH_NUM: begin
            if (status.is_cr) begin
              phase_next = PH_NUM_LF;
            end
          end
          PH_NUM_LF: begin
            if (cmd.load_pay) begin
              phase_next = PH_PAYLOAD;
            end else if (cmd.push || cmd.pop) begin
              phase_next = PH_TYPE;
            end else begin
              phase_next = PH_PAY_CR;
            end
          end
          PH_PAYLOAD: begin
            if (status.pay_last) begin
              phase_next = PH_PAY_CR;
            end
          end
          PH_PAY_CR: begin
            phase_next = PH_PAY_LF;
          end
          PH_PAY_LF: begin
            phase_next = PH_TYPE;
          end
          default: begin
            phase_next = PH_TYPE;
          end
        endcase
      end
    end
  end

endmodule

// ----- hdl/rmf_dp.sv -----
// Framing datapath: byte decode, header number, payload counter and the stack of array counts.
`timescale 1ns / 1ps

module rmf_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [7:0]                      data_byte,
  input  rmf_pkg::dp_cmd_t                cmd,
  output rmf_pkg::dp_status_t             status,
  output logic [rmf_pkg::DEPTH_W-1:0]     depth_next
);
  import rmf_pkg::*;

  kind_t              kind;
  logic               negative;
  logic [NUM_W-1:0]   hdr;
  logic [NUM_W-1:0]   pay_left;
  logic [NUM_W-1:0]   counts [MAX_DEPTH];
  logic [DEPTH_W-1:0] nest;

  logic [NUM_W+3:0]   prod;
  logic [3:0]         digit;
  logic               found;
  logic [LVL_W-1:0]   sel;
  logic [DEPTH_W-1:0] nest_pop;

  assign digit = data_byte[3:0];
  assign prod  = ({4'b0, hdr} << 3) + ({4'b0, hdr} << 1) + (NUM_W + 4)'(digit);

  always_comb begin
    found = 1'b0;
    sel   = '0;
    for (int i = 0; i < MAX_DEPTH; i++) begin
      if ((DEPTH_W'(i) < nest) && (|counts[i][NUM_W-1:1])) begin
        found = 1'b1;
        sel   = LVL_W'(i);
      end
    end
  end

  assign nest_pop = found ? (DEPTH_W'(sel) + DEPTH_W'(1)) : '0;

  always_comb begin
    status.is_cr         = (data_byte == CH_CR);
    status.is_lf         = (data_byte == CH_LF);
    status.is_digit      = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
    status.is_minus      = (data_byte == CH_MINUS);
    status.is_line_type  = (data_byte == CH_PLUS) || (data_byte == CH_MINUS) ||
                           (data_byte == CH_COLON);
    status.is_bulk_type  = (data_byte == CH_DOLLAR);
    status.is_array_type = (data_byte == CH_STAR);
    status.num_ovf       = |prod[NUM_W+3:NUM_W];
    status.hdr_zero      = (hdr == '0);
    status.hdr_one       = (hdr == NUM_W'(1));
    status.negative      = negative;
    status.kind          = kind;
    status.stack_full    = (nest >= DEPTH_W'(MAX_DEPTH));
    status.pay_last      = (pay_left <= NUM_W'(1));
    status.tree_done     = !found;
  end

  always_comb begin
    priority if (cmd.restart) begin
      depth_next = '0;
    end else if (cmd.push) begin
      depth_next = nest + DEPTH_W'(1);
    end else if (cmd.pop) begin
      depth_next = nest_pop;
    end else begin
      depth_next = nest;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      kind     <= KIND_NONE;
      negative <= 1'b0;
      hdr      <= '0;
      pay_left <= '0;
      nest     <= '0;
    end else begin
      nest <= depth_next;
      if (cmd.start_line) begin
        kind <= KIND_LINE;
      end
      if (cmd.start_num) begin
        kind     <= status.is_bulk_type ? KIND_BULK : KIND_ARRAY;
        negative <= 1'b0;
        hdr      <= '0;
      end
      if (cmd.set_neg) begin
        negative <= 1'b1;
      end
      if (cmd.add_digit) begin
        hdr <= prod[NUM_W-1:0];
      end
      if (cmd.load_pay) begin
        pay_left <= hdr;
      end
      if (cmd.dec_pay && (pay_left != '0)) begin
        pay_left <= pay_left - NUM_W'(1);
      end
      if (cmd.push || cmd.pop) begin
        kind     <= KIND_NONE;
        negative <= 1'b0;
        hdr      <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      counts[nest[LVL_W-1:0]] <= hdr;
    end else if (cmd.pop && found) begin
      counts[sel] <= counts[sel] - NUM_W'(1);
    end
  end

endmodule

// ----- hdl/resp_message_framer.sv -----
// Top level of the reply message framer: handshake, result register and checks.
`timescale 1ns / 1ps
//
// Usage:
//   Reply stream bytes enter on data_byte with byte_valid; the framer holds
//   byte_stall high while a result word is waiting and result_stall is high.
//   Each accepted byte yields exactly one registered result word:
//   message_done marks the byte that closes a top-level message, error_code
//   reports a bad type byte, a malformed header or terminator, or nesting
//   overflow, depth_now is the array nesting level after the byte, and
//   in_payload marks a counted bulk payload byte.
//   Throughput is one byte per cycle while byte_stall is low. The pop of nested
//   array counts resolves in the same cycle through parallel checks over the
//   eight-entry count stack.
//   After any error the framer drops the partial message and waits for a new
//   type byte at nesting level zero.
//   Reset (rst, synchronous) clears the phase, header, nesting level and the
//   result valid flag; the count stack needs no clearing.
//   While a result word waits under result_stall, the word holds and no byte
//   is taken; with no word waiting, a byte is taken even under result_stall.

module resp_message_framer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        byte_valid,
  output logic                        byte_stall,
  input  logic [7:0]                  data_byte,
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic                        message_done,
  output logic [1:0]                  error_code,
  output logic [3:0]                  depth_now,
  output logic                        in_payload
);
  import rmf_pkg::*;

  logic               step;
  dp_status_t         status;
  dp_cmd_t            cmd;
  err_t               err;
  logic               done;
  logic               pay;
  logic [DEPTH_W-1:0] depth_next;

  assign byte_stall = result_valid && result_stall;
  assign step       = byte_valid && !byte_stall;

  rmf_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .status (status),
    .cmd    (cmd),
    .err    (err),
    .done   (done),
    .pay    (pay)
  );

  rmf_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .data_byte  (data_byte),
    .cmd        (cmd),
    .status     (status),
    .depth_next (depth_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (step) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      message_done <= done;
      error_code   <= err;
      depth_now    <= 4'(depth_next);
      in_payload   <= pay;
    end
  end

  a_err_clears: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (error_code != ERR_NONE)) |->
      ((depth_now == 4'd0) && !message_done && !in_payload))
    else $error("error word carries nonzero depth or flags");

  a_done_top: assert property (@(posedge clk) disable iff (rst)
    (result_valid && message_done) |-> (depth_now == 4'd0))
    else $error("message done away from top level");

  a_pay_alone: assert property (@(posedge clk) disable iff (rst)
    (result_valid && in_payload) |-> (!message_done && (error_code == ERR_NONE)))
    else $error("payload byte flagged as done or error");

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (depth_now <= 4'(MAX_DEPTH)))
    else $error("nesting depth beyond stack size");

  a_step_result: assert property (@(posedge clk) disable iff (rst)
    step |=> result_valid)
    else $error("accepted byte produced no result word");

endmodule
